### hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define MPE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// antecedent implies consequent in the next cycle
`define MPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define MPE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/mpe_pkg.sv
// types and constants of the mandelbrot pixel engine
`default_nettype none
package mpe_pkg;

  localparam int unsigned IMAGE_WIDTH  = 512;
  localparam int unsigned IMAGE_HEIGHT = 512;
  localparam longint SPAN_Q = 64'sd939524096;

  localparam int unsigned CfgIdxW = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_MAX_ITER = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RE_START = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RE_STEP  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IM_START = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IM_STEP  = 3'd4;

  // reset values
  localparam logic [9:0]         MAX_ITER_RST = 10'd1000;
  localparam logic signed [31:0] RE_START_RST = -32'sd671088640;
  localparam logic signed [31:0] RE_STEP_RST  = 32'(SPAN_Q / IMAGE_WIDTH);
  localparam logic signed [31:0] IM_START_RST = -32'sd402653184;
  localparam logic signed [31:0] IM_STEP_RST  = 32'(SPAN_Q / IMAGE_HEIGHT);

  // |z|^2 bound, 4.0 in Q8.56
  localparam logic [63:0] ESCAPE_Q856 = 64'h0400_0000_0000_0000;

  typedef struct packed {
    logic [8:0] pixel_row;
    logic [8:0] pixel_col;
  } in_beat_t;

  typedef struct packed {
    logic [9:0] iter_count;
    logic       in_set;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_beat_t;

  typedef struct packed {
    logic [9:0]         max_iter;
    logic signed [31:0] re_start;
    logic signed [31:0] re_step;
    logic signed [31:0] im_start;
    logic signed [31:0] im_step;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic map_c;
    logic mul;
    logic upd;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finish;
  } sts_t;

  // saturate a wide signed value into Q4.28
  function automatic logic signed [31:0] sat_q(input logic signed [43:0] v);
    logic ovf;
    ovf = (v[43:31] != {13{1'b0}}) && (v[43:31] != {13{1'b1}});
    if (ovf) begin
      return v[43] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mpe_ctrl.sv
// controller state machine of the mandelbrot pixel engine
`default_nettype none
module mpe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire mpe_pkg::sts_t sts,
  output mpe_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAP  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_CHK  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.take     = accept;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_MAP;
      end
      ST_MAP: begin
        cmd.map_c = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sts.finish) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.upd   = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result beat valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### hw/rtl/mpe_dpath.sv
// iteration datapath and result register of the mandelbrot pixel engine
`default_nettype none
module mpe_dpath (
  input  wire logic              clk,
  input  wire mpe_pkg::in_beat_t in_data,
  input  wire mpe_pkg::cfg_t     cfg,
  input  wire mpe_pkg::cmd_t     cmd,
  output mpe_pkg::sts_t          sts,
  output mpe_pkg::out_beat_t     out_data
);

  logic [8:0]         row_r, col_r;
  logic signed [31:0] c_re_r, c_im_r;
  logic signed [31:0] x_r, y_r;
  logic signed [63:0] xx_r, yy_r, xy_r;
  logic [9:0]         n_r;
  mpe_pkg::out_beat_t res_r, res_nxt;

  // pixel to complex point
  logic signed [41:0] re_prod, im_prod;
  logic signed [43:0] re_sum, im_sum;
  assign re_prod = cfg.re_step * $signed({1'b0, col_r});
  assign im_prod = cfg.im_step * $signed({1'b0, row_r});
  assign re_sum  = {{12{cfg.re_start[31]}}, cfg.re_start} + {{2{re_prod[41]}}, re_prod};
  assign im_sum  = {{12{cfg.im_start[31]}}, cfg.im_start} + {{2{im_prod[41]}}, im_prod};

  // escape and limit test on registered squares
  logic [63:0] mag;
  assign mag = {1'b0, xx_r[62:0]} + {1'b0, yy_r[62:0]};
  assign sts.finish = (mag >= mpe_pkg::ESCAPE_Q856) || (n_r >= cfg.max_iter);

  // next z, floored back to Q4.28 and saturated
  logic signed [63:0] diff;
  logic signed [43:0] nx, ny;
  assign diff = xx_r - yy_r;
  assign nx   = {{8{diff[63]}}, diff[63:28]} + {{12{c_re_r[31]}}, c_re_r};
  assign ny   = {{7{xy_r[63]}}, xy_r[63:27]} + {{12{c_im_r[31]}}, c_im_r};

  // colour from the count
  logic [12:0] p7;
  logic [8:0]  fold;
  logic [9:0]  p10, p5;
  logic        at_limit;
  assign p10      = {n_r[6:0], 3'b000} + {n_r[8:0], 1'b0};
  assign p5       = {n_r[7:0], 2'b00} + n_r;
  assign p7       = {n_r, 3'b000} - {3'b000, n_r};
  assign fold     = {4'b0000, p7[12:8]} + {1'b0, p7[7:0]};
  assign at_limit = (n_r == cfg.max_iter);

  always_comb begin
    res_nxt            = res_r;
    res_nxt.iter_count = n_r;
    res_nxt.in_set     = at_limit;
    if (at_limit) begin
      res_nxt.red   = '0;
      res_nxt.green = '0;
      res_nxt.blue  = '0;
    end else begin
      res_nxt.red   = p10[7:0];
      res_nxt.green = p5[7:0];
      res_nxt.blue  = (fold >= 9'd255) ? 8'(fold - 9'd255) : fold[7:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      row_r <= in_data.pixel_row;
      col_r <= in_data.pixel_col;
    end
    if (cmd.map_c) begin
      c_re_r <= mpe_pkg::sat_q(re_sum);
      c_im_r <= mpe_pkg::sat_q(im_sum);
      x_r    <= '0;
      y_r    <= '0;
      n_r    <= '0;
    end else if (cmd.upd) begin
      x_r <= mpe_pkg::sat_q(nx);
      y_r <= mpe_pkg::sat_q(ny);
      n_r <= n_r + 10'd1;
    end
    if (cmd.mul) begin
      xx_r <= x_r * x_r;
      yy_r <= y_r * y_r;
      xy_r <= x_r * y_r;
    end
    if (cmd.load_out) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule
`default_nettype wire

### hw/rtl/mandelbrot_pixel_engine.sv
// Mandelbrot escape-time pixel engine, top level
//
// Input channel in_valid/in_stall/in_data carries one pixel beat (row,
// column). Result channel out_valid/out_stall/out_data carries one beat per
// pixel: iteration count, inside flag and RGB colour. The user must write
// registers through cfg_we/cfg_index/cfg_wdata only while no pixel is in
// flight; the block itself does not enforce this. One pixel is worked on at
// a time. After acceptance the MAP state maps the pixel to c, then each
// iteration passes the MUL and CHK states: MUL forms the three 32x32
// products, CHK does the escape test and the z update from the registered
// products. The default iteration limit is 1000. The next pixel is accepted
// as soon as the engine is back in idle, even while the previous result beat
// still sits in the output register. A stalled result beat holds; the engine
// then waits with its next result until that beat is taken. Synchronous
// reset restores the default view and limit and leaves the output channel
// empty.
`default_nettype none
`include "assert_macros.svh"
module mandelbrot_pixel_engine (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire mpe_pkg::in_beat_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output mpe_pkg::out_beat_t                out_data,
  input  wire logic                         cfg_we,
  input  wire logic [mpe_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]                  cfg_wdata
);

  mpe_pkg::cfg_t cfg_r, cfg_nxt;
  mpe_pkg::cmd_t cmd;
  mpe_pkg::sts_t sts;

  // configuration register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mpe_pkg::CFG_MAX_ITER: cfg_nxt.max_iter = cfg_wdata[9:0];
        mpe_pkg::CFG_RE_START: cfg_nxt.re_start = cfg_wdata;
        mpe_pkg::CFG_RE_STEP:  cfg_nxt.re_step  = cfg_wdata;
        mpe_pkg::CFG_IM_START: cfg_nxt.im_start = cfg_wdata;
        mpe_pkg::CFG_IM_STEP:  cfg_nxt.im_step  = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iter <= mpe_pkg::MAX_ITER_RST;
      cfg_r.re_start <= mpe_pkg::RE_START_RST;
      cfg_r.re_step  <= mpe_pkg::RE_STEP_RST;
      cfg_r.im_start <= mpe_pkg::IM_START_RST;
      cfg_r.im_step  <= mpe_pkg::IM_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpe_dpath u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // checks
  `MPE_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
  `MPE_ASSERT_IMP(a_black_inside, clk, rst_n, out_valid && out_data.in_set, out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
  `MPE_ASSERT_IMP(a_blue_range, clk, rst_n, out_valid, out_data.blue != 8'hFF)
  `MPE_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.load_out, !out_valid || !out_stall)

endmodule
`default_nettype wire
